// ===== design/assert_macros.svh =====
// Assertion macros shared by the terminal scroller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define TMTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked on every clock edge outside reset.
`define TMTS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/tmts_pkg.sv =====
// Types and fixed constants of the text-mode terminal scroller.
`timescale 1ns / 1ps
`default_nettype none

package tmts_pkg;

	localparam int KIND_W      = 1;
	localparam int CODE_W      = 8;
	localparam int ROW_FIELD_W = 5;
	localparam int COL_FIELD_W = 7;
	localparam int ATTR_W      = 8;
	localparam int CELL_W      = 16;

	localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [CODE_W-1:0] BLANK_CODE   = 8'h20;
	localparam logic [ATTR_W-1:0] RESET_COLOR  = 8'h0F;

	localparam logic [KIND_W-1:0] KIND_WRITE = 1'b0;
	localparam logic [KIND_W-1:0] KIND_READ  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCR_RD,
		ST_SCR_WR,
		ST_FILL,
		ST_RESULT
	} state_t;

endpackage

`default_nettype wire

// ===== design/tmts_in_if.sv =====
// Command channel: character write or cell read request.
`timescale 1ns / 1ps
`default_nettype none

interface tmts_in_if;
	logic                               valid;
	logic                               ready;
	logic [tmts_pkg::KIND_W-1:0]        kind;
	logic [tmts_pkg::CODE_W-1:0]        char_code;
	logic [tmts_pkg::ROW_FIELD_W-1:0]   read_row;
	logic [tmts_pkg::COL_FIELD_W-1:0]   read_col;

	modport source (output valid, kind, char_code, read_row, read_col, input ready);
	modport sink   (input valid, kind, char_code, read_row, read_col, output ready);
endinterface

`default_nettype wire

// ===== design/tmts_out_if.sv =====
// Response channel: read cell and cursor position.
`timescale 1ns / 1ps
`default_nettype none

interface tmts_out_if;
	logic                               valid;
	logic                               ready;
	logic [tmts_pkg::CELL_W-1:0]        cell_data;
	logic [tmts_pkg::ROW_FIELD_W-1:0]   cursor_row;
	logic [tmts_pkg::COL_FIELD_W-1:0]   cursor_col;
	logic                               scrolled;

	modport source (output valid, cell_data, cursor_row, cursor_col, scrolled, input ready);
	modport sink   (input valid, cell_data, cursor_row, cursor_col, scrolled, output ready);
endinterface

`default_nettype wire

// ===== design/tmts_screen_ram.sv =====
// Screen cell store: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none

module tmts_screen_ram #(
	parameter int DEPTH  = 2000,
	parameter int ADDR_W = 11,
	parameter int DATA_W = 16
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== design/text_mode_terminal_scroller_core.sv =====
// Text terminal core: after reset the block clears the whole screen store
// (ROWS*COLUMNS cells, 2000 at 80x25) to white-on-black blanks and is not
// ready meanwhile. A read, a newline or a printed character is taken in the
// idle state; the block then passes to the result state, loads the result
// into the output register and returns to idle to take the next word. An
// item that scrolls first passes through the scroll states: the screen store
// is swept one cell at a time, a read then a write, to move rows up, then the
// last row is filled. One item is in work at a time; a new one is taken while
// the last result still waits in the output register, and a stalled output
// holds the next result back for as long as the stall lasts.
`timescale 1ns / 1ps
`default_nettype none

module text_mode_terminal_scroller_core #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	tmts_in_if.sink                            cmd,
	tmts_out_if.source                         rsp,
	input  wire logic                          cfg_we,
	input  wire logic [tmts_pkg::ATTR_W-1:0]   cfg_wdata
);

	`include "assert_macros.svh"

	localparam int CELLS     = ROWS * COLUMNS;
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int ROW_W     = $clog2(ROWS);
	localparam int COL_W     = $clog2(COLUMNS);
	localparam int COPY_LAST = (ROWS - 1) * COLUMNS - 1;

	localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] ADDR_COPY = ADDR_W'(COPY_LAST);
	localparam logic [ADDR_W-1:0] ADDR_ROW  = ADDR_W'(COLUMNS);
	localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
	localparam logic [COL_W:0]    COL_END   = (COL_W + 1)'(COLUMNS);

	tmts_pkg::state_t state_q, state_d;

	logic [ADDR_W-1:0]           addr_q;
	logic [ROW_W-1:0]            cur_y_q;
	logic [COL_W-1:0]            cur_x_q;
	logic [tmts_pkg::ATTR_W-1:0] text_color_q;
	logic                        pend_read_q;
	logic                        pend_hit_q;
	logic                        pend_scr_q;

	logic                          out_valid_q;
	logic [tmts_pkg::CELL_W-1:0]   out_cell_q;
	logic [ROW_W-1:0]              out_row_q;
	logic [COL_W-1:0]              out_col_q;
	logic                          out_scr_q;

	logic                        ram_we;
	logic [ADDR_W-1:0]           ram_waddr;
	logic [tmts_pkg::CELL_W-1:0] ram_wdata;
	logic                        ram_re;
	logic [ADDR_W-1:0]           ram_raddr;
	logic [tmts_pkg::CELL_W-1:0] ram_rdata;

	logic              cmd_ready;
	logic              accept;
	logic              is_read;
	logic              is_nl;
	logic              rd_hit;
	logic [COL_W:0]    x_inc;
	logic              x_wrap;
	logic              y_last;
	logic              need_scroll;
	logic [ADDR_W-1:0] cur_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic              load_result;

	// Decode of the word at the command port
	assign accept      = cmd.valid && cmd_ready;
	assign is_read     = (cmd.kind == tmts_pkg::KIND_READ);
	assign is_nl       = (cmd.char_code == tmts_pkg::NEWLINE_CODE);
	assign rd_hit      = (int'(cmd.read_row) < ROWS) && (int'(cmd.read_col) < COLUMNS);
	assign x_inc       = {1'b0, cur_x_q} + (COL_W + 1)'(1);
	assign x_wrap      = is_nl || (x_inc == COL_END);
	assign y_last      = (cur_y_q == ROW_LAST);
	assign need_scroll = !is_read && x_wrap && y_last;
	assign cur_addr    = ADDR_W'(cur_y_q) * ADDR_ROW + ADDR_W'(cur_x_q);
	assign rd_addr     = ADDR_W'(cmd.read_row) * ADDR_ROW + ADDR_W'(cmd.read_col);

	always_comb begin
		state_d = state_q;
		case (state_q)
			tmts_pkg::ST_CLEAR: begin
				if (addr_q == ADDR_LAST) state_d = tmts_pkg::ST_IDLE;
			end
			tmts_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = need_scroll ? tmts_pkg::ST_SCR_RD : tmts_pkg::ST_RESULT;
				end
			end
			tmts_pkg::ST_SCR_RD: state_d = tmts_pkg::ST_SCR_WR;
			tmts_pkg::ST_SCR_WR: begin
				state_d = (addr_q == ADDR_COPY) ? tmts_pkg::ST_FILL : tmts_pkg::ST_SCR_RD;
			end
			tmts_pkg::ST_FILL: begin
				if (addr_q == ADDR_LAST) state_d = tmts_pkg::ST_RESULT;
			end
			tmts_pkg::ST_RESULT: begin
				if (!out_valid_q || rsp.ready) state_d = tmts_pkg::ST_IDLE;
			end
			default: state_d = tmts_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd_ready   = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = addr_q;
		ram_wdata   = {tmts_pkg::RESET_COLOR, tmts_pkg::BLANK_CODE};
		ram_re      = 1'b0;
		ram_raddr   = addr_q + ADDR_ROW;
		load_result = 1'b0;
		case (state_q)
			tmts_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
			end
			tmts_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				ram_we    = accept && !is_read && !is_nl;
				ram_waddr = cur_addr;
				ram_wdata = {text_color_q, cmd.char_code};
				ram_re    = accept && is_read && rd_hit;
				ram_raddr = rd_addr;
			end
			tmts_pkg::ST_SCR_RD: begin
				ram_re = 1'b1;
			end
			tmts_pkg::ST_SCR_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			tmts_pkg::ST_FILL: begin
				ram_we    = 1'b1;
				ram_wdata = {text_color_q, tmts_pkg::BLANK_CODE};
			end
			tmts_pkg::ST_RESULT: begin
				load_result = !out_valid_q || rsp.ready;
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tmts_pkg::ST_CLEAR;
			addr_q       <= '0;
			cur_y_q      <= '0;
			cur_x_q      <= '0;
			text_color_q <= tmts_pkg::RESET_COLOR;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == tmts_pkg::ST_IDLE) begin
				addr_q <= '0;
			end else if (ram_we) begin
				addr_q <= addr_q + ADDR_W'(1);
			end
			if (accept && !is_read) begin
				cur_x_q <= x_wrap ? '0 : x_inc[COL_W-1:0];
				if (x_wrap && !y_last) cur_y_q <= cur_y_q + ROW_W'(1);
			end
			if (cfg_we) text_color_q <= cfg_wdata;
			if (load_result) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item context and result word need no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			pend_read_q <= is_read;
			pend_hit_q  <= rd_hit;
			pend_scr_q  <= need_scroll;
		end
		if (load_result) begin
			out_cell_q <= (pend_read_q && pend_hit_q) ? ram_rdata : '0;
			out_row_q  <= cur_y_q;
			out_col_q  <= cur_x_q;
			out_scr_q  <= pend_scr_q;
		end
	end

	tmts_screen_ram #(
		.DEPTH  (CELLS),
		.ADDR_W (ADDR_W),
		.DATA_W (tmts_pkg::CELL_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cmd.ready      = cmd_ready;
	assign rsp.valid      = out_valid_q;
	assign rsp.cell_data  = out_cell_q;
	assign rsp.cursor_row = tmts_pkg::ROW_FIELD_W'(out_row_q);
	assign rsp.cursor_col = tmts_pkg::COL_FIELD_W'(out_col_q);
	assign rsp.scrolled   = out_scr_q;

	`TMTS_ASSERT(a_result_from_result_state, $rose(out_valid_q) |-> $past(state_q == tmts_pkg::ST_RESULT), "result word loaded outside result state")
	`TMTS_ASSERT_IMPL(a_fill_on_last_row, state_q == tmts_pkg::ST_FILL, cur_y_q == ROW_LAST, "scroll fill with cursor off the last row")
	`TMTS_ASSERT_IMPL(a_scroll_col_zero, out_valid_q && out_scr_q, out_col_q == '0 && out_row_q == ROW_LAST, "scrolled result with cursor not at start of last row")

endmodule

`default_nettype wire
